FILE: rtl/cll_pkg.sv
// Shared constants, codes and control/status structs for the cursor linked-list engine.
package cll_pkg;

  localparam int NODE_COUNT_DEF  = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 8;
  localparam int IOVAL_W = 32;
  localparam int NIDX_W  = 8;
  localparam int LEN_W   = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRED   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd5;

  // read address select
  localparam logic [1:0] RA_ZERO = 2'd0;
  localparam logic [1:0] RA_HEAD = 2'd1;
  localparam logic [1:0] RA_LINK = 2'd2;

  // link write address select
  localparam logic [2:0] WA_IDX  = 3'd0;
  localparam logic [2:0] WA_ZERO = 3'd1;
  localparam logic [2:0] WA_HEAD = 3'd2;
  localparam logic [2:0] WA_NODE = 3'd3;
  localparam logic [2:0] WA_HOLD = 3'd4;
  localparam logic [2:0] WA_FREE = 3'd5;

  // link write data select
  localparam logic [2:0] WD_INIT   = 3'd0;
  localparam logic [2:0] WD_TNEXT  = 3'd1;
  localparam logic [2:0] WD_NODE   = 3'd2;
  localparam logic [2:0] WD_FREE   = 3'd3;
  localparam logic [2:0] WD_RDLINK = 3'd4;
  localparam logic [2:0] WD_ZERO   = 3'd5;

  typedef struct packed {
    logic       load_in;
    logic [1:0] ra_sel;
    logic       link_we;
    logic [2:0] wa_sel;
    logic [2:0] wd_sel;
    logic       val_we;
    logic       ld_free;
    logic       ld_tnext;
    logic       ld_node_link;
    logic       ld_node_addr;
    logic       ld_hold_addr;
    logic       ld_hold_prev;
    logic       ld_vout_rd;
    logic       ld_vout_pv;
    logic       ld_nidx;
    logic       set_ok;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
  } cll_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             clr;
    logic [POS_W-1:0] pos;
    logic             match;
  } cll_sts_t;

endpackage

FILE: rtl/cll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/cll_datapath.sv
// Datapath: link and value memories, walk registers, result registers.
module cll_datapath import cll_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cll_ctl_t                      ctl,
  input  logic [$clog2(NODE_COUNT)-1:0] idx,
  input  logic [CMD_W-1:0]              in_cmd,
  input  logic [POS_W-1:0]              in_position,
  input  logic signed [IOVAL_W-1:0]     in_value,
  input  logic                          in_clear_list,
  output cll_sts_t                      sts,
  output logic [$clog2(NODE_COUNT)-1:0] cnt,
  output logic                          out_status,
  output logic signed [IOVAL_W-1:0]     out_value_out,
  output logic [NIDX_W-1:0]             out_node_index,
  output logic [LEN_W-1:0]              out_list_length,
  output logic                          out_list_empty
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int VW = VALUE_WIDTH;
  localparam int CAP = NODE_COUNT - 2;
  localparam logic [IW-1:0] HEAD = IW'(NODE_COUNT - 1);

  logic [CMD_W-1:0] cmd_r;
  logic             clr_r;
  logic [POS_W-1:0] pos_r;
  logic [VW-1:0]    v_r;
  logic [IW-1:0]    addr_r, prev_r, free_r, tnext_r, node_r, hold_r, nidx_r, cnt_r;
  logic [VW-1:0]    pval_r, vout_r;
  logic             status_r;

  logic [IW-1:0] raddr, link_rd, waddr, wdata;
  logic [VW-1:0] val_rd, v_ext;
  logic [IOVAL_W-1:0] vout_wide;

  // sign-extend or trim the input value to the stored width, and the stored value to the output width
  always_comb begin
    for (int i = 0; i < VW; i++) begin
      v_ext[i] = in_value[(i < IOVAL_W) ? i : IOVAL_W - 1];
    end
    for (int i = 0; i < IOVAL_W; i++) begin
      vout_wide[i] = vout_r[(i < VW) ? i : VW - 1];
    end
  end

  always_comb begin
    case (ctl.ra_sel)
      RA_HEAD: raddr = HEAD;
      RA_LINK: raddr = link_rd;
      default: raddr = '0;
    endcase
  end

  always_comb begin
    case (ctl.wa_sel)
      WA_IDX:  waddr = idx;
      WA_ZERO: waddr = '0;
      WA_HEAD: waddr = HEAD;
      WA_NODE: waddr = node_r;
      WA_HOLD: waddr = hold_r;
      WA_FREE: waddr = free_r;
      default: waddr = '0;
    endcase
  end

  always_comb begin
    case (ctl.wd_sel)
      WD_INIT:   wdata = ({1'b0, idx} < (IW+1)'(CAP)) ? idx + IW'(1) : '0;
      WD_TNEXT:  wdata = tnext_r;
      WD_NODE:   wdata = node_r;
      WD_FREE:   wdata = free_r;
      WD_RDLINK: wdata = link_rd;
      WD_ZERO:   wdata = '0;
      default:   wdata = '0;
    endcase
  end

  cll_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (ctl.link_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (link_rd)
  );

  cll_ram #(.WIDTH(VW), .DEPTH(NODE_COUNT)) u_val_ram (
    .clk   (clk),
    .we    (ctl.val_we),
    .waddr (free_r),
    .wdata (v_r),
    .raddr (raddr),
    .rdata (val_rd)
  );

  always_ff @(posedge clk) begin
    addr_r <= raddr;
    prev_r <= addr_r;
    pval_r <= val_rd;
    if (ctl.load_in) begin
      cmd_r <= in_cmd;
      clr_r <= in_clear_list;
      pos_r <= in_position;
      v_r   <= v_ext;
    end
    if (ctl.ld_free)      free_r  <= link_rd;
    if (ctl.ld_tnext)     tnext_r <= link_rd;
    if (ctl.ld_node_link) node_r  <= link_rd;
    if (ctl.ld_node_addr) node_r  <= addr_r;
    if (ctl.ld_hold_addr) hold_r  <= addr_r;
    if (ctl.ld_hold_prev) hold_r  <= prev_r;
    if (ctl.load_in) begin
      vout_r <= '0;
      nidx_r <= '0;
    end else begin
      if (ctl.ld_vout_rd) vout_r <= val_rd;
      if (ctl.ld_vout_pv) vout_r <= pval_r;
      if (ctl.ld_nidx)    nidx_r <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      status_r <= 1'b1;
    end else begin
      if (ctl.load_in) begin
        status_r <= 1'b1;
      end else if (ctl.set_ok) begin
        status_r <= 1'b0;
      end
      if (ctl.cnt_clr) begin
        cnt_r <= '0;
      end else if (ctl.cnt_inc) begin
        cnt_r <= cnt_r + IW'(1);
      end else if (ctl.cnt_dec) begin
        cnt_r <= cnt_r - IW'(1);
      end
    end
  end

  assign sts.cmd   = cmd_r;
  assign sts.clr   = clr_r;
  assign sts.pos   = pos_r;
  assign sts.match = (val_rd == v_r);
  assign cnt       = cnt_r;

  assign out_status      = status_r;
  assign out_value_out   = status_r ? '0 : vout_wide;
  assign out_node_index  = NIDX_W'(nidx_r);
  assign out_list_length = LEN_W'(cnt_r);
  assign out_list_empty  = (cnt_r == '0);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= (IW+1)'(CAP))
    else $error("element count above capacity");

endmodule

FILE: rtl/cll_ctrl.sv
// Controller: link-table init sweep, command decode and list walk sequencing.
module cll_ctrl import cll_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  cll_sts_t                      sts,
  input  logic [$clog2(NODE_COUNT)-1:0] cnt,
  output cll_ctl_t                      ctl,
  output logic [$clog2(NODE_COUNT)-1:0] idx
);

  localparam int IW  = $clog2(NODE_COUNT);
  localparam int JW  = $clog2(NODE_COUNT + 1);
  localparam int CW  = (JW > POS_W + 1) ? JW : POS_W + 1;
  localparam int CAP = NODE_COUNT - 2;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_INS1  = 5'd3;
  localparam logic [4:0] S_INS2  = 5'd4;
  localparam logic [4:0] S_WALK  = 5'd5;
  localparam logic [4:0] S_INSW0 = 5'd6;
  localparam logic [4:0] S_INSW1 = 5'd7;
  localparam logic [4:0] S_INSW2 = 5'd8;
  localparam logic [4:0] S_DEL1  = 5'd9;
  localparam logic [4:0] S_DEL2  = 5'd10;
  localparam logic [4:0] S_DEL3  = 5'd11;
  localparam logic [4:0] S_CLR1  = 5'd12;
  localparam logic [4:0] S_CLRW0 = 5'd13;
  localparam logic [4:0] S_CLRW1 = 5'd14;
  localparam logic [4:0] S_CLRW2 = 5'd15;
  localparam logic [4:0] S_SUCC  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]    state_r, state_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [CW-1:0] pos_e, cnt_e, j_e;

  assign pos_e = CW'(sts.pos);
  assign cnt_e = CW'(cnt);
  assign j_e   = CW'(j_r);
  assign idx   = j_r[IW-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    ctl       = '0;
    ctl.ra_sel = RA_LINK;
    case (state_r)
      S_INIT: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_IDX;
        ctl.wd_sel  = WD_INIT;
        j_nxt       = j_r + JW'(1);
        if (j_r == JW'(NODE_COUNT - 1)) begin
          j_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        j_nxt = JW'(1);
        if (sts.clr) begin
          if (cnt == '0) begin
            ctl.set_ok = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            ctl.ra_sel = RA_ZERO;
            state_nxt  = S_CLR1;
          end
        end else begin
          case (sts.cmd)
            CMD_INSERT: begin
              if (pos_e == '0 || pos_e > cnt_e + CW'(1) || cnt_e >= CW'(CAP)) begin
                state_nxt = S_DONE;
              end else begin
                ctl.ra_sel = RA_ZERO;
                state_nxt  = S_INS1;
              end
            end
            CMD_DELETE, CMD_READ: begin
              if (pos_e == '0 || pos_e > cnt_e) begin
                state_nxt = S_DONE;
              end else begin
                ctl.ra_sel = RA_HEAD;
                state_nxt  = S_WALK;
              end
            end
            CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
              ctl.ra_sel = RA_HEAD;
              state_nxt  = S_WALK;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS1: begin
        ctl.ld_free = 1'b1;
        state_nxt   = S_INS2;
      end
      S_INS2: begin
        ctl.ld_tnext = 1'b1;
        ctl.ra_sel   = RA_HEAD;
        j_nxt        = JW'(1);
        state_nxt    = S_WALK;
      end
      S_CLR1: begin
        ctl.ld_free = 1'b1;
        ctl.ra_sel  = RA_HEAD;
        j_nxt       = JW'(1);
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        j_nxt = j_r + JW'(1);
        if (sts.clr) begin
          if (j_r == JW'(1)) ctl.ld_node_link = 1'b1;
          if (j_e == cnt_e + CW'(1)) begin
            ctl.ld_hold_addr = 1'b1;
            state_nxt        = S_CLRW0;
          end
        end else begin
          case (sts.cmd)
            CMD_INSERT: begin
              if (j_e == pos_e) begin
                ctl.ld_hold_addr = 1'b1;
                ctl.ld_node_link = 1'b1;
                state_nxt        = S_INSW0;
              end
            end
            CMD_DELETE: begin
              if (j_e == pos_e + CW'(1)) begin
                ctl.ld_node_addr = 1'b1;
                ctl.ld_tnext     = 1'b1;
                ctl.ld_hold_prev = 1'b1;
                ctl.ld_vout_rd   = 1'b1;
                ctl.ra_sel       = RA_ZERO;
                state_nxt        = S_DEL1;
              end
            end
            CMD_READ: begin
              if (j_e == pos_e + CW'(1)) begin
                ctl.ld_vout_rd = 1'b1;
                ctl.set_ok     = 1'b1;
                state_nxt      = S_DONE;
              end
            end
            CMD_LOCATE: begin
              if (j_e >= CW'(2) && sts.match) begin
                ctl.ld_nidx = 1'b1;
                ctl.set_ok  = 1'b1;
                state_nxt   = S_DONE;
              end else if (j_e >= cnt_e + CW'(1)) begin
                state_nxt = S_DONE;
              end
            end
            CMD_PRED: begin
              if (j_e >= CW'(3) && sts.match) begin
                ctl.ld_vout_pv = 1'b1;
                ctl.set_ok     = 1'b1;
                state_nxt      = S_DONE;
              end else if (j_e >= cnt_e + CW'(1)) begin
                state_nxt = S_DONE;
              end
            end
            CMD_SUCC: begin
              if (j_e >= CW'(2) && j_e <= cnt_e && sts.match) begin
                state_nxt = S_SUCC;
              end else if (j_e >= cnt_e) begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INSW0: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_ZERO;
        ctl.wd_sel  = WD_TNEXT;
        ctl.val_we  = 1'b1;
        state_nxt   = S_INSW1;
      end
      S_INSW1: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_FREE;
        ctl.wd_sel  = WD_NODE;
        state_nxt   = S_INSW2;
      end
      S_INSW2: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_HOLD;
        ctl.wd_sel  = WD_FREE;
        ctl.cnt_inc = 1'b1;
        ctl.set_ok  = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DEL1: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_NODE;
        ctl.wd_sel  = WD_RDLINK;
        state_nxt   = S_DEL2;
      end
      S_DEL2: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_HOLD;
        ctl.wd_sel  = WD_TNEXT;
        state_nxt   = S_DEL3;
      end
      S_DEL3: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_ZERO;
        ctl.wd_sel  = WD_NODE;
        ctl.cnt_dec = 1'b1;
        ctl.set_ok  = 1'b1;
        state_nxt   = S_DONE;
      end
      S_CLRW0: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_HOLD;
        ctl.wd_sel  = WD_FREE;
        state_nxt   = S_CLRW1;
      end
      S_CLRW1: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_ZERO;
        ctl.wd_sel  = WD_NODE;
        state_nxt   = S_CLRW2;
      end
      S_CLRW2: begin
        ctl.link_we = 1'b1;
        ctl.wa_sel  = WA_HEAD;
        ctl.wd_sel  = WD_ZERO;
        ctl.cnt_clr = 1'b1;
        ctl.set_ok  = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SUCC: begin
        ctl.ld_vout_rd = 1'b1;
        ctl.set_ok     = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result side open together");

  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready && !out_valid)
    else $error("accepted word did not start work");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (j_e <= cnt_e + CW'(1)))
    else $error("walk ran past the end of the list");

endmodule

FILE: rtl/cursor_linked_list_engine.sv
// Top level of the cursor linked-list engine: controller plus datapath.
//
// Array-backed linked list of NODE_COUNT nodes: node 0 heads the free list
// and node NODE_COUNT-1 heads the data list, so up to NODE_COUNT-2 elements
// fit. Each input word runs one command (insert, delete, read at a 1-based
// position, locate, predecessor, successor, or clear when in_clear_list is
// set) and returns exactly one result word with the list length and empty
// flag. Work is one command at a time: in_ready is high only while idle,
// and the result stays on the out_ port until taken. Rejected commands
// skip the walk; the run time of the others is set by the list walk,
// which follows one link per clock through the registered read port of the
// link memory; a walk covers at most length+1 hops. After reset the link
// memory is initialized by a sweep over all NODE_COUNT entries, during
// which no word is accepted.
module cursor_linked_list_engine import cll_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [IOVAL_W-1:0] in_value,
  input  logic                      in_clear_list,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_status,
  output logic signed [IOVAL_W-1:0] out_value_out,
  output logic [NIDX_W-1:0]         out_node_index,
  output logic [LEN_W-1:0]          out_list_length,
  output logic                      out_list_empty
);

  localparam int IW = $clog2(NODE_COUNT);

  cll_ctl_t      ctl;
  cll_sts_t      sts;
  logic [IW-1:0] cnt;
  logic [IW-1:0] idx;

  // sequence commands, walk and memory writes
  cll_ctrl #(.NODE_COUNT(NODE_COUNT)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cnt       (cnt),
    .ctl       (ctl),
    .idx       (idx)
  );

  // hold the memories, walk pointers and the result word
  cll_datapath #(.NODE_COUNT(NODE_COUNT), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .idx             (idx),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .in_clear_list   (in_clear_list),
    .sts             (sts),
    .cnt             (cnt),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_node_index  (out_node_index),
    .out_list_length (out_list_length),
    .out_list_empty  (out_list_empty)
  );

endmodule
